// ===== rtl/btbp_pkg.sv =====
// Shared types and constants of the two-level branch predictor with BTB.
package btbp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam int PC_IDX_LSB = 2;
	localparam int GSHARE_LSB = 16;
	localparam int INSN_BYTES = 4;
	localparam int IDX_CAP    = 5;
	localparam int IDX_SPAN   = 1 << IDX_CAP;
	localparam int CTR_W      = 2;

	localparam logic [CTR_W-1:0] CTR_RST       = 2'd1;
	localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
	localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
	localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;

	localparam logic [1:0] SHARE_NONE = 2'd0;
	localparam logic [1:0] SHARE_LOW  = 2'd1;
	localparam logic [1:0] SHARE_HIGH = 2'd2;

	typedef enum logic {
		KIND_PREDICT = 1'b0,
		KIND_UPDATE  = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BTB_INDEX_BITS  = 3'd0,
		CFG_HISTORY_LENGTH  = 3'd1,
		CFG_TAG_BITS        = 3'd2,
		CFG_DEFAULT_COUNTER = 3'd3,
		CFG_GLOBAL_HISTORY  = 3'd4,
		CFG_GLOBAL_TABLE    = 3'd5,
		CFG_SHARE_MODE      = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0] btb_index_bits;
		logic [3:0] history_length;
		logic [4:0] tag_bits;
		logic [1:0] default_counter;
		logic       global_history_mode;
		logic       global_table_mode;
		logic [1:0] share_mode;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		btb_index_bits:      3'd5,
		history_length:      4'd8,
		tag_bits:            5'd30,
		default_counter:     2'd1,
		global_history_mode: 1'b0,
		global_table_mode:   1'b0,
		share_mode:          SHARE_NONE
	};

endpackage

// ===== rtl/btbp_if.sv =====
// Request and response channel interfaces of the branch predictor.
interface btbp_req_if;
	logic              valid;
	logic              ready;
	btbp_pkg::kind_t   kind;
	logic [31:0]       pc;
	logic [31:0]       actual_target;
	logic              was_taken;
	logic [31:0]       earlier_guess;

	modport source(output valid, kind, pc, actual_target, was_taken, earlier_guess,
		input ready);
	modport sink(input valid, kind, pc, actual_target, was_taken, earlier_guess,
		output ready);
endinterface

interface btbp_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_fetch;
	logic        guess_taken;
	logic        flush;
	logic [31:0] branch_total;
	logic [31:0] flush_total;

	modport source(output valid, next_fetch, guess_taken, flush, branch_total, flush_total,
		input ready);
	modport sink(input valid, next_fetch, guess_taken, flush, branch_total, flush_total,
		output ready);
endinterface

// ===== rtl/btbp_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read data.
module btbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/btbp_addr.sv =====
// Splits a PC into BTB slot, tag and counter-table row under the current configuration.
module btbp_addr #(
	parameter int BTB_ENTRIES = 32,
	parameter int TAG_MAX = 30,
	localparam int SLOT_W = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1,
	localparam int TAG_W = (TAG_MAX > 0) ? TAG_MAX : 1,
	localparam int ROW_AW = $clog2(BTB_ENTRIES + 1)
) (
	input  btbp_pkg::cfg_t    cfg,
	input  logic [31:0]       pc,
	output logic [SLOT_W-1:0] slot,
	output logic [TAG_W-1:0]  tag,
	output logic [ROW_AW-1:0] row
);
	import btbp_pkg::*;

	localparam logic [ROW_AW-1:0] SHARED_ROW = ROW_AW'(BTB_ENTRIES);

	logic [2:0]         ib;
	logic [IDX_CAP-1:0] imask;
	logic [IDX_CAP-1:0] raw;
	logic [4:0]         tb;
	logic [TAG_W-1:0]   tmask;
	logic [2:0]         shamt;
	logic [31:0]        shifted;
	logic [SLOT_W-1:0]  slot_lut [IDX_SPAN];

	// The index wraps modulo the entry count; the remainders are fixed at elaboration.
	for (genvar g = 0; g < IDX_SPAN; g++) begin : g_lut
		localparam int SLOT_VAL = g % BTB_ENTRIES;
		assign slot_lut[g] = SLOT_W'(SLOT_VAL);
	end

	always_comb begin
		ib = (cfg.btb_index_bits > 3'(IDX_CAP)) ? 3'(IDX_CAP) : cfg.btb_index_bits;
		for (int i = 0; i < IDX_CAP; i++) begin
			imask[i] = (3'(i) < ib);
		end
		raw = pc[PC_IDX_LSB +: IDX_CAP] & imask;
		slot = slot_lut[raw];

		tb = (cfg.tag_bits > 5'(TAG_MAX)) ? 5'(TAG_MAX) : cfg.tag_bits;
		for (int i = 0; i < TAG_W; i++) begin
			tmask[i] = (5'(i) < tb);
		end
		shamt = 3'(PC_IDX_LSB) + ib;
		shifted = pc >> shamt;
		tag = shifted[TAG_W-1:0] & tmask;

		row = cfg.global_table_mode ? SHARED_ROW : ROW_AW'(slot);
	end

endmodule

// ===== rtl/btbp_ctr.sv =====
// Selects one 2-bit counter from a table row and builds the row with that counter moved.
module btbp_ctr #(
	parameter int HIST_MAX = 8,
	localparam int NCTR = 1 << HIST_MAX,
	localparam int ROW_W = btbp_pkg::CTR_W * NCTR
) (
	input  logic [ROW_W-1:0]            row_data,
	input  logic                        row_valid,
	input  logic                        refill,
	input  logic [btbp_pkg::CTR_W-1:0]  fill_val,
	input  logic [HIST_MAX-1:0]         idx,
	input  logic                        taken,
	output logic [btbp_pkg::CTR_W-1:0]  ctr,
	output logic [ROW_W-1:0]            row_next
);
	import btbp_pkg::*;

	logic [ROW_W-1:0] base;
	logic [CTR_W-1:0] ctr_nxt;

	always_comb begin
		// A row never written since reset reads as the reset counter value.
		if (refill) begin
			base = {NCTR{fill_val}};
		end else if (row_valid) begin
			base = row_data;
		end else begin
			base = {NCTR{CTR_RST}};
		end
		ctr = base[{idx, 1'b0} +: CTR_W];
		if (taken) begin
			ctr_nxt = (ctr == CTR_MAX) ? ctr : ctr + CTR_W'(1);
		end else begin
			ctr_nxt = (ctr == CTR_MIN) ? ctr : ctr - CTR_W'(1);
		end
	end

	for (genvar i = 0; i < NCTR; i++) begin : g_row
		assign row_next[CTR_W*i +: CTR_W] =
			(idx == HIST_MAX'(i)) ? ctr_nxt : base[CTR_W*i +: CTR_W];
	end

endmodule

// ===== rtl/btb_two_level_branch_predictor.sv =====
// Branch target buffer with two-level (local/global, lshare/gshare) direction prediction.
// Throughput: one request per cycle, predicts and updates alike, with no bubbles while rsp.ready is high.
// Path: an accepted request loads the input stage and the counter-row read; leaving the
// input stage, it loads the output register, where the response waits until rsp.ready.
// Reset: arst_n clears all entries, histories, counts and the configuration at once;
// counter rows read as the reset counter value until written, so no clearing pass runs.
module btb_two_level_branch_predictor #(
	parameter int BTB_ENTRIES = 32,
	parameter int HIST_MAX = 8,
	parameter int TAG_MAX = 30
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [btbp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [btbp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	btbp_req_if.sink                         req,
	btbp_rsp_if.source                       rsp
);
	import btbp_pkg::*;

	localparam int SLOT_W = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
	localparam int TAG_W = (TAG_MAX > 0) ? TAG_MAX : 1;
	localparam int ROWS = BTB_ENTRIES + 1;
	localparam int ROW_AW = $clog2(ROWS);
	localparam int NCTR = 1 << HIST_MAX;
	localparam int ROW_W = CTR_W * NCTR;

	// Configuration registers; the user must write them only while the block is idle (not enforced here).
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_BTB_INDEX_BITS:  cfg_q.btb_index_bits <= cfg_wdata[2:0];
				CFG_HISTORY_LENGTH:  cfg_q.history_length <= cfg_wdata[3:0];
				CFG_TAG_BITS:        cfg_q.tag_bits <= cfg_wdata[4:0];
				CFG_DEFAULT_COUNTER: cfg_q.default_counter <= cfg_wdata[1:0];
				CFG_GLOBAL_HISTORY:  cfg_q.global_history_mode <= cfg_wdata[0];
				CFG_GLOBAL_TABLE:    cfg_q.global_table_mode <= cfg_wdata[0];
				CFG_SHARE_MODE:      cfg_q.share_mode <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Handshake. The input stage moves forward whenever the output register is free
	// or is being emptied, so a waiting response blocks the next request only once
	// the input stage also holds an item.
	logic valid_s1;
	logic out_valid_q;
	logic adv;
	logic acc;
	logic fire;

	assign adv = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign acc = req.valid && req.ready;
	assign fire = valid_s1 && adv;

	// The PC is split at acceptance so the counter-row read can start in the same edge.
	logic [SLOT_W-1:0] slot_in;
	logic [TAG_W-1:0]  tag_in;
	logic [ROW_AW-1:0] row_in;

	btbp_addr #(
		.BTB_ENTRIES(BTB_ENTRIES),
		.TAG_MAX(TAG_MAX)
	) u_addr (
		.cfg(cfg_q),
		.pc(req.pc),
		.slot(slot_in),
		.tag(tag_in),
		.row(row_in)
	);

	// Input stage.
	kind_t             kind_s1;
	logic [31:0]       pc_s1;
	logic [31:0]       tgt_s1;
	logic              taken_s1;
	logic [31:0]       guess_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [ROW_AW-1:0] row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= req.kind;
			pc_s1 <= req.pc;
			tgt_s1 <= req.actual_target;
			taken_s1 <= req.was_taken;
			guess_s1 <= req.earlier_guess;
			slot_s1 <= slot_in;
			tag_s1 <= tag_in;
			row_s1 <= row_in;
		end
	end

	// BTB entries. Tags and targets are only looked at behind the valid bit.
	logic              valid_q   [BTB_ENTRIES];
	logic [TAG_W-1:0]  tag_q     [BTB_ENTRIES];
	logic [31:0]       target_q  [BTB_ENTRIES];
	logic [HIST_MAX-1:0] hist_q  [BTB_ENTRIES];
	logic [HIST_MAX-1:0] shist_q;
	logic              row_valid_q [ROWS];
	logic [31:0]       brc_q;
	logic [31:0]       flc_q;

	// Counter tables: one row per BTB entry plus one shared row at the top address.
	// Allocation rewrites the whole row, so each row holds every counter of its table.
	logic             ram_we;
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_wr;

	btbp_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_ctr_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(row_s1),
		.wdata(row_wr),
		.re(acc),
		.raddr(row_in),
		.rdata(row_rd)
	);

	// Prediction and update logic for the item in the input stage.
	logic                is_upd;
	logic                hit;
	logic                alloc;
	logic [3:0]          hl;
	logic [HIST_MAX-1:0] hmask;
	logic [HIST_MAX-1:0] h_cur;
	logic [HIST_MAX-1:0] pcx;
	logic [HIST_MAX-1:0] ci;
	logic [HIST_MAX-1:0] h_new;
	logic [CTR_W-1:0]    ctr;
	logic [31:0]         seq;
	logic [31:0]         dst;
	logic                pred_taken;
	logic                fl;
	logic [31:0]         brc_nxt;
	logic [31:0]         flc_nxt;

	always_comb begin
		is_upd = (kind_s1 == KIND_UPDATE);
		hit = valid_q[slot_s1] && (tag_q[slot_s1] == tag_s1);
		alloc = is_upd && !hit;

		// History length is clamped to 1..HIST_MAX before it forms the mask.
		if (cfg_q.history_length == 4'd0) begin
			hl = 4'd1;
		end else if (cfg_q.history_length > 4'(HIST_MAX)) begin
			hl = 4'(HIST_MAX);
		end else begin
			hl = cfg_q.history_length;
		end
		for (int i = 0; i < HIST_MAX; i++) begin
			hmask[i] = (4'(i) < hl);
		end

		// A freshly allocated entry starts its local history from zero.
		if (cfg_q.global_history_mode) begin
			h_cur = shist_q;
		end else if (alloc) begin
			h_cur = '0;
		end else begin
			h_cur = hist_q[slot_s1];
		end

		case (cfg_q.share_mode)
			SHARE_LOW:  pcx = pc_s1[PC_IDX_LSB +: HIST_MAX];
			SHARE_HIGH: pcx = pc_s1[GSHARE_LSB +: HIST_MAX];
			default:    pcx = '0;
		endcase
		ci = (h_cur ^ pcx) & hmask;
		h_new = HIST_MAX'({h_cur, taken_s1}) & hmask;

		seq = pc_s1 + 32'(INSN_BYTES);
		pred_taken = hit && (ctr >= CTR_TAKEN_MIN);
		dst = pred_taken ? target_q[slot_s1] : seq;
		fl = is_upd && (taken_s1 ? (tgt_s1 != guess_s1) : (guess_s1 != seq));

		brc_nxt = brc_q + 32'(is_upd);
		flc_nxt = flc_q + 32'(fl);
		ram_we = fire && is_upd;
	end

	btbp_ctr #(
		.HIST_MAX(HIST_MAX)
	) u_ctr (
		.row_data(row_rd),
		.row_valid(row_valid_q[row_s1]),
		.refill(alloc && !cfg_q.global_table_mode),
		.fill_val(cfg_q.default_counter),
		.idx(ci),
		.taken(taken_s1),
		.ctr(ctr),
		.row_next(row_wr)
	);

	// State updates take effect as the item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BTB_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				hist_q[i] <= '0;
			end
			for (int i = 0; i < ROWS; i++) begin
				row_valid_q[i] <= 1'b0;
			end
			shist_q <= '0;
			brc_q <= '0;
			flc_q <= '0;
		end else if (fire) begin
			brc_q <= brc_nxt;
			flc_q <= flc_nxt;
			if (is_upd) begin
				valid_q[slot_s1] <= 1'b1;
				row_valid_q[row_s1] <= 1'b1;
				if (cfg_q.global_history_mode) begin
					shist_q <= h_new;
				end else begin
					hist_q[slot_s1] <= h_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_upd) begin
			tag_q[slot_s1] <= tag_s1;
			target_q[slot_s1] <= tgt_s1;
		end
	end

	// Output register.
	logic [31:0] nf_q;
	logic        gt_q;
	logic        fl_q;
	logic [31:0] bt_q;
	logic [31:0] ft_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			nf_q <= is_upd ? '0 : dst;
			gt_q <= !is_upd && (dst != seq);
			fl_q <= fl;
			bt_q <= brc_nxt;
			ft_q <= flc_nxt;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.next_fetch = nf_q;
	assign rsp.guess_taken = gt_q;
	assign rsp.flush = fl_q;
	assign rsp.branch_total = bt_q;
	assign rsp.flush_total = ft_q;

	// An update leaves its entry valid.
	a_upd_allocates: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_upd) |=> valid_q[$past(slot_s1)])
		else $error("updated BTB entry not valid");

	// The branch count moves by one per update and holds otherwise.
	a_brc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_upd) |=> (brc_q == $past(brc_q) + 32'd1))
		else $error("branch count did not advance on update");

	a_brc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && is_upd) |=> $stable(brc_q))
		else $error("branch count changed without update");

	// Requests are refused only while both stages hold an item.
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && out_valid_q && !rsp.ready))
		else $error("request refused with room in the pipeline");

	// A predicted-taken response never also reports a flush.
	a_pred_no_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && gt_q) |-> !fl_q)
		else $error("predict response carries a flush");

endmodule
